### hdl/battery_monitor_spi_sequencer_defines.svh
// ----------------------------------------------------------------------------
// battery monitor spi sequencer assertion macros
// shared checks with clock and synchronous reset handling
// ----------------------------------------------------------------------------
`ifndef BATTERY_MONITOR_SPI_SEQUENCER_DEFINES_SVH
`define BATTERY_MONITOR_SPI_SEQUENCER_DEFINES_SVH

// check that is off while reset is held
`define BMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that also holds during reset
`define BMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/bms_seq_pkg.sv
// ----------------------------------------------------------------------------
// bms_seq_pkg
// types and constants shared by the sequencer controller and datapath
// ----------------------------------------------------------------------------
package bms_seq_pkg;

    // result kinds
    localparam logic [2:0] KIND_SEND    = 3'd0;
    localparam logic [2:0] KIND_RELEASE = 3'd1;
    localparam logic [2:0] KIND_CELL    = 3'd2;
    localparam logic [2:0] KIND_OPEN    = 3'd3;
    localparam logic [2:0] KIND_TEMP    = 3'd4;

    // messages on the bus
    localparam logic [2:0] MSG_IDLE       = 3'd0;
    localparam logic [2:0] MSG_CFG_WRITE  = 3'd1;
    localparam logic [2:0] MSG_CELL_START = 3'd2;
    localparam logic [2:0] MSG_OPEN_START = 3'd3;
    localparam logic [2:0] MSG_CELL_READ  = 3'd4;
    localparam logic [2:0] MSG_TEMP_START = 3'd5;
    localparam logic [2:0] MSG_TEMP_READ  = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_RUN_ENABLE     = 2'd0;
    localparam logic [1:0] REG_CONFIG_BYTES   = 2'd1;
    localparam logic [1:0] REG_DISCHARGE_MASK = 2'd2;

    // first bytes of each message
    localparam logic [7:0] CMD_CFG_FIRST   = 8'h01;
    localparam logic [7:0] CMD_CELL_START  = 8'h10;
    localparam logic [7:0] CMD_CELL_READ   = 8'h04;
    localparam logic [7:0] CMD_OPEN_START  = 8'h20;
    localparam logic [7:0] CMD_TEMP_START  = 8'h33;
    localparam logic [7:0] CMD_TEMP_READ   = 8'h0E;
    localparam logic [7:0] BYTE_CFG_PEC    = 8'hC7;
    localparam logic [7:0] BYTE_CELL_PEC   = 8'hB0;
    localparam logic [7:0] BYTE_OPEN_PEC   = 8'h20;
    localparam logic [7:0] BYTE_TEMP_PEC   = 8'h59;
    localparam logic [7:0] BYTE_CREAD_PEC  = 8'hDC;
    localparam logic [7:0] BYTE_TREAD_PEC  = 8'hEA;
    localparam logic [7:0] BYTE_DUMMY      = 8'hFF;

    localparam logic [7:0]  CRC_SEED       = 8'h41;
    localparam logic [7:0]  CRC_POLY       = 8'h07;
    localparam logic [11:0] ADC_OFFSET     = 12'd512;
    localparam logic [47:0] CONFIG_RESET   = 48'hE1;
    localparam logic [2:0]  CFG_LAST_BYTE  = 3'd5;

    typedef enum logic [2:0] {
        EM_TEMP,
        EM_CELL_EVEN,
        EM_CELL_ODD,
        EM_CMD,
        EM_XCHG
    } t_emit_sel;

    typedef struct packed {
        logic       in_take;
        logic       emit;
        t_emit_sel  sel;
        logic       last;
        logic       wait_req;
        logic       cell_open;
        logic [7:0] tx_byte;
        logic [3:0] cell_idx;
        logic [2:0] msg;
        logic [4:0] pos;
        logic       xchg_end;
        logic       crc_step;
        logic       crc_first;
        logic [2:0] crc_idx;
        logic       rd_en;
        logic [4:0] rd_addr;
        logic       latch_b0;
        logic       latch_b1;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic run_enable;
    } t_status;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  tx_byte;
        logic [3:0]  cell_index;
        logic [12:0] value;
        logic        wait_request;
        logic        last;
    } t_result;

endpackage

### hdl/battery_monitor_spi_sequencer.sv
// ----------------------------------------------------------------------------
// battery_monitor_spi_sequencer
// spi command sequencer for a battery-monitor chip with pec and conversions
// ----------------------------------------------------------------------------
// channel   direction  word
// s_axis    in         tuser opcode, tdata rx_byte
// m_axis    out        tuser kind, tdata tx/cell/value/wait, tlast last
// cfg       in         i_cfg_we / i_cfg_index / i_cfg_data
//
// byte exchange word: registered into the result register from the exchange state
// poll words: command steps emit the command byte; step zero emits the temperature,
//   runs the crc over the config bytes, then the command; cell steps emit each cell plus command
// one word at a time, bounded by the controller state machine
// reset is synchronous, active low; read-back store reads zero until written
// a stalled m_axis holds the sequencer, s_axis is taken only when idle
// ----------------------------------------------------------------------------
module battery_monitor_spi_sequencer #(
    parameter int CELL_COUNT      = 12,
    parameter int CELL_READ_BYTES = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  logic        s_axis_tuser,   // opcode
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // tx_byte[7:0], cell_index[11:8],
                                        // value[24:12], wait_request[25], zero
    output logic [2:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);
    import bms_seq_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_result result;

    // controller: step, message, byte position
    bms_seq_ctrl #(
        .CELL_COUNT      (CELL_COUNT),
        .CELL_READ_BYTES (CELL_READ_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: registers, store, crc, conversions, output register
    bms_seq_dp #(
        .CELL_READ_BYTES (CELL_READ_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx_byte   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result)
    );

    // pack result word, highest field first
    assign m_axis_tdata = {6'd0, result.wait_request, result.value,
                           result.cell_index, result.tx_byte};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

endmodule

### hdl/bms_seq_dp.sv
// ----------------------------------------------------------------------------
// bms_seq_dp
// config registers, read-back store, pec crc, conversions and output register
// ----------------------------------------------------------------------------
module bms_seq_dp #(
    parameter int CELL_READ_BYTES = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [47:0]          i_cfg_data,
    input  logic [7:0]           i_rx_byte,
    input  bms_seq_pkg::t_cmd    i_cmd,
    output bms_seq_pkg::t_status o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output bms_seq_pkg::t_result o_result
);
    import bms_seq_pkg::*;

    localparam int SW = (CELL_READ_BYTES > 1) ? $clog2(CELL_READ_BYTES) : 1;

    logic                       r_run_enable;
    logic [47:0]                r_config_bytes;
    logic [11:0]                r_discharge_mask;
    logic [7:0]                 r_rx;
    logic [7:0]                 r_store [CELL_READ_BYTES];
    logic [CELL_READ_BYTES-1:0] r_store_valid;
    logic [7:0]                 r_rd;
    logic [7:0]                 r_b0;
    logic [7:0]                 r_b1;
    logic [7:0]                 r_temp0;
    logic [7:0]                 r_temp1;
    logic [7:0]                 r_crc;
    logic                       r_out_valid;
    t_result                    r_out;

    t_result    n_out;
    logic [7:0] xchg_byte;
    logic [7:0] crc_in;
    logic       store_wr;
    logic [4:0] store_addr;
    logic [11:0] cell_raw;
    logic [11:0] cell_diff;
    logic [13:0] cell_x3;
    logic [11:0] temp_raw;
    logic [11:0] temp_diff;
    logic [13:0] temp_x3;

    function automatic logic [7:0] cfg_byte(input logic [2:0] idx, input logic [47:0] cfg,
                                            input logic [11:0] mask);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = cfg[7:0];
            3'd1:    b = mask[7:0];
            3'd2:    b = {cfg[23:20], mask[11:8]};
            3'd3:    b = cfg[31:24];
            3'd4:    b = cfg[39:32];
            3'd5:    b = cfg[47:40];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // msb-first crc-8, one byte
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ d[i];
            c  = {c[6:0], 1'b0};
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    assign crc_in = i_cmd.crc_first ? CRC_SEED : r_crc;

    // byte to send during a message exchange
    always_comb begin
        xchg_byte = BYTE_DUMMY;
        unique case (i_cmd.msg)
            MSG_CFG_WRITE: begin
                if (i_cmd.pos == 5'd0)      xchg_byte = BYTE_CFG_PEC;
                else if (i_cmd.pos == 5'd7) xchg_byte = r_crc;
                else xchg_byte = cfg_byte(3'(i_cmd.pos - 5'd1), r_config_bytes,
                                          r_discharge_mask);
            end
            MSG_CELL_START: xchg_byte = BYTE_CELL_PEC;
            MSG_OPEN_START: xchg_byte = BYTE_OPEN_PEC;
            MSG_TEMP_START: xchg_byte = BYTE_TEMP_PEC;
            MSG_CELL_READ:  xchg_byte = (i_cmd.pos == 5'd0) ? BYTE_CREAD_PEC : BYTE_DUMMY;
            MSG_TEMP_READ:  xchg_byte = (i_cmd.pos == 5'd0) ? BYTE_TREAD_PEC : BYTE_DUMMY;
            default:        xchg_byte = BYTE_DUMMY;
        endcase
    end

    assign store_wr   = i_cmd.emit && (i_cmd.sel == EM_XCHG) && !i_cmd.xchg_end
                        && (i_cmd.msg == MSG_CELL_READ) && (i_cmd.pos >= 5'd2);
    assign store_addr = i_cmd.pos - 5'd2;

    // conversions, offset floored at zero
    assign cell_raw  = (i_cmd.sel == EM_CELL_EVEN) ? {r_b1[3:0], r_b0} : {r_rd, r_b1[7:4]};
    assign cell_diff = (cell_raw > ADC_OFFSET) ? cell_raw - ADC_OFFSET : 12'd0;
    assign cell_x3   = {2'b00, cell_diff} + {1'b0, cell_diff, 1'b0};
    assign temp_raw  = {r_temp1[3:0], r_temp0};
    assign temp_diff = (temp_raw > ADC_OFFSET) ? temp_raw - ADC_OFFSET : 12'd0;
    assign temp_x3   = {2'b00, temp_diff} + {1'b0, temp_diff, 1'b0};

    always_comb begin
        n_out              = '0;
        n_out.last         = i_cmd.last;
        n_out.wait_request = i_cmd.wait_req;
        unique case (i_cmd.sel)
            EM_TEMP: begin
                n_out.kind  = KIND_TEMP;
                n_out.value = 13'(temp_x3[13:4]);
            end
            EM_CELL_EVEN, EM_CELL_ODD: begin
                n_out.kind       = i_cmd.cell_open ? KIND_OPEN : KIND_CELL;
                n_out.cell_index = i_cmd.cell_idx;
                n_out.value      = cell_x3[13:1];
            end
            EM_CMD: begin
                n_out.kind    = KIND_SEND;
                n_out.tx_byte = i_cmd.tx_byte;
            end
            EM_XCHG: begin
                n_out.kind    = i_cmd.xchg_end ? KIND_RELEASE : KIND_SEND;
                n_out.tx_byte = i_cmd.xchg_end ? 8'h00 : xchg_byte;
            end
            default: n_out.kind = KIND_SEND;
        endcase
    end

    // store payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_store[store_addr[SW-1:0]] <= r_rx;
        end
        if (i_cmd.in_take) begin
            r_rx <= i_rx_byte;
        end
        if (i_cmd.latch_b0) r_b0 <= r_rd;
        if (i_cmd.latch_b1) r_b1 <= r_rd;
        if (i_cmd.emit) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable     <= 1'b0;
            r_config_bytes   <= CONFIG_RESET;
            r_discharge_mask <= 12'd0;
            r_store_valid    <= '0;
            r_rd             <= 8'h00;
            r_temp0          <= 8'h00;
            r_temp1          <= 8'h00;
            r_crc            <= CRC_SEED;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_RUN_ENABLE:     r_run_enable     <= i_cfg_data[0];
                    REG_CONFIG_BYTES:   r_config_bytes   <= i_cfg_data;
                    REG_DISCHARGE_MASK: r_discharge_mask <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (store_wr) r_store_valid[store_addr[SW-1:0]] <= 1'b1;
            if (i_cmd.rd_en) begin
                if ((i_cmd.rd_addr < 5'(CELL_READ_BYTES))
                        && r_store_valid[i_cmd.rd_addr[SW-1:0]]) begin
                    r_rd <= r_store[i_cmd.rd_addr[SW-1:0]];
                end else begin
                    r_rd <= 8'h00;
                end
            end
            if (i_cmd.emit && (i_cmd.sel == EM_XCHG) && !i_cmd.xchg_end
                    && (i_cmd.msg == MSG_TEMP_READ)) begin
                if (i_cmd.pos == 5'd5) r_temp0 <= r_rx;
                if (i_cmd.pos == 5'd6) r_temp1 <= r_rx;
            end
            if (i_cmd.crc_step) begin
                r_crc <= crc8_byte(crc_in, cfg_byte(i_cmd.crc_idx, r_config_bytes,
                                                    r_discharge_mask));
            end
            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.run_enable = r_run_enable;
    assign o_out_valid         = r_out_valid;
    assign o_result            = r_out;

endmodule

### hdl/bms_seq_ctrl.sv
// ----------------------------------------------------------------------------
// bms_seq_ctrl
// sequence step, active message and byte position; drives the datapath
// ----------------------------------------------------------------------------
`include "battery_monitor_spi_sequencer_defines.svh"

module bms_seq_ctrl #(
    parameter int CELL_COUNT      = 12,
    parameter int CELL_READ_BYTES = 18
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_opcode,
    output logic                 o_in_ready,
    input  bms_seq_pkg::t_status i_status,
    output bms_seq_pkg::t_cmd    o_cmd
);
    import bms_seq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_XCHG,
        S_TEMP,
        S_CRC,
        S_CMD,
        S_RD0,
        S_RD1,
        S_RD2,
        S_EVEN,
        S_ODD
    } t_state;

    t_state     r_state;
    logic [2:0] r_step;
    logic [2:0] r_active;
    logic [4:0] r_pos;
    logic [2:0] r_crc_idx;
    logic [3:0] r_cell;
    logic [4:0] r_addr;

    logic       xchg_end;
    logic [7:0] step_byte;
    logic [2:0] step_msg;
    logic       step_wait;
    logic [2:0] step_next;
    logic       cell_done;

    // end of message once all bytes are out
    always_comb begin
        unique case (r_active)
            MSG_CFG_WRITE:  xchg_end = (r_pos >= 5'd8);
            MSG_CELL_READ:  xchg_end = (r_pos >= 5'(CELL_READ_BYTES + 2));
            MSG_TEMP_READ:  xchg_end = (r_pos >= 5'd7);
            default:        xchg_end = (r_pos >= 5'd1);
        endcase
    end

    always_comb begin
        step_wait = 1'b0;
        unique case (r_step)
            3'd0: begin step_byte = CMD_CFG_FIRST;  step_msg = MSG_CFG_WRITE;  step_next = 3'd1; end
            3'd1: begin
                step_byte = CMD_CELL_START; step_msg = MSG_CELL_START; step_next = 3'd2;
                step_wait = 1'b1;
            end
            3'd2: begin step_byte = CMD_CELL_READ;  step_msg = MSG_CELL_READ;  step_next = 3'd3; end
            3'd3: begin
                step_byte = CMD_OPEN_START; step_msg = MSG_OPEN_START; step_next = 3'd4;
                step_wait = 1'b1;
            end
            3'd4: begin step_byte = CMD_CELL_READ;  step_msg = MSG_CELL_READ;  step_next = 3'd5; end
            3'd5: begin step_byte = CMD_TEMP_START; step_msg = MSG_TEMP_START; step_next = 3'd6; end
            3'd6: begin step_byte = CMD_TEMP_READ;  step_msg = MSG_TEMP_READ;  step_next = 3'd0; end
            default: begin step_byte = 8'h00; step_msg = MSG_IDLE; step_next = 3'd0; end
        endcase
    end

    assign cell_done  = (r_cell == 4'(CELL_COUNT - 1));
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.sel       = EM_CMD;
        o_cmd.msg       = r_active;
        o_cmd.pos       = r_pos;
        o_cmd.xchg_end  = xchg_end;
        o_cmd.crc_idx   = r_crc_idx;
        o_cmd.crc_first = (r_crc_idx == 3'd0);
        o_cmd.rd_addr   = r_addr;
        o_cmd.cell_idx  = r_cell;
        o_cmd.cell_open = (r_step == 3'd5);
        o_cmd.tx_byte   = step_byte;
        unique case (r_state)
            S_IDLE: o_cmd.in_take = i_in_valid;
            S_XCHG: begin
                o_cmd.sel  = EM_XCHG;
                o_cmd.emit = i_status.out_free;
                o_cmd.last = 1'b1;
            end
            S_TEMP: begin
                o_cmd.sel  = EM_TEMP;
                o_cmd.emit = i_status.out_free;
            end
            S_CRC:  o_cmd.crc_step = 1'b1;
            S_CMD: begin
                o_cmd.emit     = i_status.out_free;
                o_cmd.last     = 1'b1;
                o_cmd.wait_req = step_wait;
            end
            S_RD0:  o_cmd.rd_en = 1'b1;
            S_RD1: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.latch_b0 = 1'b1;
            end
            S_RD2: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.latch_b1 = 1'b1;
            end
            S_EVEN: begin
                o_cmd.sel  = EM_CELL_EVEN;
                o_cmd.emit = i_status.out_free;
            end
            S_ODD: begin
                o_cmd.sel  = EM_CELL_ODD;
                o_cmd.emit = i_status.out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= 3'd0;
            r_active  <= MSG_IDLE;
            r_pos     <= 5'd0;
            r_crc_idx <= 3'd0;
            r_cell    <= 4'd0;
            r_addr    <= 5'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_crc_idx <= 3'd0;
                        r_cell    <= 4'd0;
                        r_addr    <= 5'd0;
                        if (i_opcode) begin
                            if (r_active != MSG_IDLE) r_state <= S_XCHG;
                        end else if (r_active == MSG_IDLE && i_status.run_enable) begin
                            priority case (r_step)
                                3'd0:       r_state <= S_TEMP;
                                3'd3, 3'd5: r_state <= S_RD0;
                                3'd7:       r_step  <= 3'd0;
                                default:    r_state <= S_CMD;
                            endcase
                        end
                    end
                end
                S_XCHG: begin
                    if (i_status.out_free) begin
                        if (xchg_end) r_active <= MSG_IDLE;
                        else r_pos <= r_pos + 5'd1;
                        r_state <= S_IDLE;
                    end
                end
                S_TEMP: if (i_status.out_free) r_state <= S_CRC;
                S_CRC: begin
                    r_crc_idx <= r_crc_idx + 3'd1;
                    if (r_crc_idx == CFG_LAST_BYTE) r_state <= S_CMD;
                end
                S_CMD: begin
                    if (i_status.out_free) begin
                        r_active <= step_msg;
                        r_pos    <= 5'd0;
                        r_step   <= step_next;
                        r_state  <= S_IDLE;
                    end
                end
                S_RD0: begin
                    r_addr  <= r_addr + 5'd1;
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_addr  <= r_addr + 5'd1;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_addr  <= r_addr + 5'd1;
                    r_state <= S_EVEN;
                end
                S_EVEN: begin
                    if (i_status.out_free) begin
                        r_cell  <= r_cell + 4'd1;
                        r_state <= cell_done ? S_CMD : S_ODD;
                    end
                end
                S_ODD: begin
                    if (i_status.out_free) begin
                        r_cell  <= r_cell + 4'd1;
                        r_state <= cell_done ? S_CMD : S_RD0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BMS_ASSERT(a_emit_needs_room, o_cmd.emit |-> i_status.out_free, "emit with output full")
    `BMS_ASSERT(a_xchg_has_msg, (r_state == S_XCHG) |-> (r_active != MSG_IDLE), "exchange while idle")
    `BMS_ASSERT(a_cmd_opens_msg, (r_state == S_CMD && i_status.out_free) |=> (r_active != MSG_IDLE), "command left bus idle")
    `BMS_ASSERT(a_pos_bound, r_pos <= 5'(CELL_READ_BYTES + 2), "byte position out of range")

endmodule
